>>> design/complex_magnitude_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex magnitude block
// Each macro expects aclk and aresetn in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MAGNITUDE_DEFINES_SVH
`define COMPLEX_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define CMAG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("complex_magnitude: assertion failed");

// Next-cycle implication, checked out of reset only.
`define CMAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("complex_magnitude: assertion failed");

`endif

>>> design/cmag_pkg.sv
// ----------------------------------------------------------------------------
// cmag_pkg
// Widths and beat types shared by the complex magnitude pipeline.
// ----------------------------------------------------------------------------
package cmag_pkg;

    // Sample component width; the design holds for 4 to 32.
    localparam int DATA_WIDTH = 16;
    localparam int SUM_W      = 2 * DATA_WIDTH;
    localparam int SQRT_STEPS = DATA_WIDTH;
    localparam int REM_W      = DATA_WIDTH + 1;
    localparam int S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic                         last;
        logic signed [DATA_WIDTH-1:0] im;
        logic signed [DATA_WIDTH-1:0] re;
    } sample_t;

    typedef struct packed {
        logic    valid;
        sample_t sample;
    } sample_beat_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SUM_W-1:0] sum;
    } sum_beat_t;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [DATA_WIDTH-1:0] mag;
    } mag_beat_t;

endpackage

>>> design/cmag_skid.sv
// ----------------------------------------------------------------------------
// cmag_skid
// Input skid stage: registered tready, holds one beat while the pipe stalls.
// ----------------------------------------------------------------------------
`include "complex_magnitude_defines.svh"

module cmag_skid (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cmag_pkg::S_TDATA_W-1:0]  s_tdata,   // re, im
    input  logic                            s_tlast,
    input  logic                            en,
    output cmag_pkg::sample_beat_t          feed
);
    import cmag_pkg::*;

    logic    skid_valid_reg;
    logic    skid_valid_next;
    sample_t skid_data_reg;
    sample_t in_sample;
    logic    accept;

    assign in_sample.re   = s_tdata[DATA_WIDTH-1:0];
    assign in_sample.im   = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign in_sample.last = s_tlast;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && !skid_valid_reg;

    // Park the beat when the pipe is frozen, release it on the next advance.
    assign skid_valid_next = (skid_valid_reg || accept) && !en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !en) begin
            skid_data_reg <= in_sample;
        end
    end

    assign feed.valid  = skid_valid_reg || s_tvalid;
    assign feed.sample = skid_valid_reg ? skid_data_reg : in_sample;

    `CMAG_ASSERT_NEXT(a_skid_hold, skid_valid_reg && !en, skid_valid_reg)
    `CMAG_ASSERT_IMP(a_skid_fill, $rose(skid_valid_reg), $past(s_tvalid && !en))

endmodule

>>> design/cmag_square.sv
// ----------------------------------------------------------------------------
// cmag_square
// Three stages: absolute values, squares, sum of squares.
// ----------------------------------------------------------------------------
module cmag_square (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  cmag_pkg::sample_beat_t feed,
    output cmag_pkg::sum_beat_t    sum_out
);
    import cmag_pkg::*;

    logic [DATA_WIDTH-1:0] re_u;
    logic [DATA_WIDTH-1:0] im_u;
    logic [DATA_WIDTH-1:0] abs_re_next;
    logic [DATA_WIDTH-1:0] abs_im_next;
    logic [DATA_WIDTH-1:0] abs_re_reg;
    logic [DATA_WIDTH-1:0] abs_im_reg;
    logic [SUM_W-1:0]      sq_re_next;
    logic [SUM_W-1:0]      sq_im_next;
    logic [SUM_W-1:0]      sq_re_reg;
    logic [SUM_W-1:0]      sq_im_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [2:0]            valid_reg;
    logic [2:0]            last_reg;

    // The most negative value maps to its true magnitude as unsigned.
    assign re_u        = feed.sample.re;
    assign im_u        = feed.sample.im;
    assign abs_re_next = re_u[DATA_WIDTH-1] ? (~re_u) + DATA_WIDTH'(1) : re_u;
    assign abs_im_next = im_u[DATA_WIDTH-1] ? (~im_u) + DATA_WIDTH'(1) : im_u;

    assign sq_re_next = SUM_W'(abs_re_reg) * SUM_W'(abs_re_reg);
    assign sq_im_next = SUM_W'(abs_im_reg) * SUM_W'(abs_im_reg);

    // Cannot overflow: the sum peaks at 2^(SUM_W-1).
    assign sum_next = sq_re_reg + sq_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], feed.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg   <= {last_reg[1:0], feed.sample.last};
            abs_re_reg <= abs_re_next;
            abs_im_reg <= abs_im_next;
            sq_re_reg  <= sq_re_next;
            sq_im_reg  <= sq_im_next;
            sum_reg    <= sum_next;
        end
    end

    assign sum_out.valid = valid_reg[2];
    assign sum_out.last  = last_reg[2];
    assign sum_out.sum   = sum_reg;

endmodule

>>> design/cmag_sqrt.sv
// ----------------------------------------------------------------------------
// cmag_sqrt
// Pipelined integer square root, one result bit per stage, MSB first.
// ----------------------------------------------------------------------------
`include "complex_magnitude_defines.svh"

module cmag_sqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  cmag_pkg::sum_beat_t   sum_in,
    output cmag_pkg::mag_beat_t   mag_out
);
    import cmag_pkg::*;

    logic [REM_W-1:0]      rem_reg   [SQRT_STEPS];
    logic [REM_W-1:0]      rem_next  [SQRT_STEPS];
    logic [DATA_WIDTH-1:0] root_reg  [SQRT_STEPS];
    logic [DATA_WIDTH-1:0] root_next [SQRT_STEPS];
    logic [SUM_W-1:0]      x_reg     [SQRT_STEPS];
    logic [SUM_W-1:0]      x_next    [SQRT_STEPS];
    logic                  valid_reg [SQRT_STEPS];
    logic                  last_reg  [SQRT_STEPS];
    logic [REM_W-1:0]      twice_root;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        logic [REM_W-1:0]      rem_in;
        logic [DATA_WIDTH-1:0] root_in;
        logic [SUM_W-1:0]      x_in;
        logic                  valid_in;
        logic                  last_in;
        logic [REM_W+1:0]      rem_cat;
        logic [REM_W+1:0]      trial;
        logic [REM_W+1:0]      diff;
        logic                  take;

        if (i == 0) begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign x_in     = sum_in.sum;
            assign valid_in = sum_in.valid;
            assign last_in  = sum_in.last;
        end else begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign x_in     = x_reg[i-1];
            assign valid_in = valid_reg[i-1];
            assign last_in  = last_reg[i-1];
        end

        // Bring down the next two radicand bits, try root*4+1.
        assign rem_cat = {rem_in, x_in[SUM_W-1 -: 2]};
        assign trial   = {1'b0, root_in, 2'b01};
        assign diff    = rem_cat - trial;
        assign take    = rem_cat >= trial;

        assign rem_next[i]  = take ? diff[REM_W-1:0] : rem_cat[REM_W-1:0];
        assign root_next[i] = {root_in[DATA_WIDTH-2:0], take};
        assign x_next[i]    = {x_in[SUM_W-3:0], 2'b00};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                x_reg[i]    <= x_next[i];
                last_reg[i] <= last_in;
            end
        end
    end

    assign mag_out.valid = valid_reg[SQRT_STEPS-1];
    assign mag_out.last  = last_reg[SQRT_STEPS-1];
    assign mag_out.mag   = root_reg[SQRT_STEPS-1];

    assign twice_root = {root_reg[SQRT_STEPS-1], 1'b0};

    // A floor root leaves a remainder of at most twice the root.
    `CMAG_ASSERT_IMP(a_sqrt_rem, valid_reg[SQRT_STEPS-1], rem_reg[SQRT_STEPS-1] <= twice_root)

endmodule

>>> design/complex_magnitude.sv
// Beats pass the abs, square and sum stages, the root stages and the output register.
// Throughput: one beat per cycle unless stalled; one square root stage per result bit.
// A stall on the result side freezes the whole pipe; one beat parks in the input skid.
// Reset (aresetn low, synchronous) clears all valid bits and the skid; data is kept.
// ----------------------------------------------------------------------------
// complex_magnitude
// Streaming floor(sqrt(re^2 + im^2)) of signed complex samples, last flag copied.
// ----------------------------------------------------------------------------
module complex_magnitude (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cmag_pkg::S_TDATA_W-1:0] s_tdata,   // re, im (from bit 0 up)
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cmag_pkg::M_TDATA_W-1:0] m_tdata,   // magnitude (from bit 0 up)
    output logic                           m_tlast
);
    import cmag_pkg::*;

    sample_beat_t          feed;
    sum_beat_t             sum_beat;
    mag_beat_t             mag_beat;
    logic                  en;
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic [DATA_WIDTH-1:0] out_mag_reg;

    // Advance every stage together whenever the output slot is free or being
    // drained; otherwise hold everything in place.
    assign en = !out_valid_reg || m_tready;

    // Input skid: keeps tready a pure register output.
    cmag_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .en       (en),
        .feed     (feed)
    );

    // Absolute value, squaring and summation, one stage each.
    cmag_square u_square (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .feed    (feed),
        .sum_out (sum_beat)
    );

    // Bit-per-stage square root.
    cmag_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .sum_in  (sum_beat),
        .mag_out (mag_beat)
    );

    // Output register: the beat stays here until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= mag_beat.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_mag_reg  <= mag_beat.mag;
            out_last_reg <= mag_beat.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    // Pad the magnitude with zeros to whole bytes.
    assign m_tdata  = M_TDATA_W'(out_mag_reg);

endmodule
